FILE: design/bblgc_pkg.sv
// shared types and codes for the glyph cache directory
package bblgc_pkg;

	localparam int unsigned KEY_W    = 60;
	localparam int unsigned PPU_W    = 32;
	localparam int unsigned BYTES_W  = 25;
	localparam int unsigned STAMP_W  = 48;
	localparam int unsigned TAG_W    = 32;
	localparam int unsigned PREFIX_W = KEY_W - PPU_W;
	localparam int unsigned RATIO_W  = 16;
	localparam int unsigned PROD_W   = RATIO_W + PPU_W;
	localparam logic [3:0]  MAX_SAMPLES = 4'd8;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_STORE  = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [2:0] ST_HIT     = 3'd0;
	localparam logic [2:0] ST_SOURCE  = 3'd1;
	localparam logic [2:0] ST_MISS    = 3'd2;
	localparam logic [2:0] ST_EVICTED = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;
	localparam logic [2:0] ST_STORED  = 3'd5;
	localparam logic [2:0] ST_NOSTORE = 3'd6;
	localparam logic [2:0] ST_INVALID = 3'd7;

	localparam logic [0:0] REG_CAPACITY = 1'b0;
	localparam logic [0:0] REG_RATIO    = 1'b1;

	localparam logic [BYTES_W-1:0] CAPACITY_RESET = 25'd65536;
	localparam logic [RATIO_W-1:0] RATIO_RESET    = 16'd512;

	typedef struct packed {
		logic [1:0]         command;
		logic [7:0]         font_id;
		logic [15:0]        glyph_number;
		logic [3:0]         samples_axis;
		logic [PPU_W-1:0]   scale_ppu;
		logic [BYTES_W-1:0] entry_bytes;
		logic [TAG_W-1:0]   payload_tag;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [TAG_W-1:0]   result_payload;
		logic [PPU_W-1:0]   result_ppu;
		logic [5:0]         slot_index;
		logic [BYTES_W-1:0] bytes_in_use;
		logic               last;
	} rsp_t;

endpackage

FILE: design/bblgc_ram.sv
// generic single-write, single-read ram with registered read data
module bblgc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: design/byte_budget_lru_glyph_cache.sv
// glyph cache directory: byte budget, lru replacement, sequential slot scans
// lookup: a product step, then a scan of one slot per cycle, then a stamp touch on a find
// store: one lru scan per eviction, then a write of the chosen slot
// clear: each valid slot is read, then freed; one request at a time, one compare unit reused
// async active-low reset empties all slots, zeroes byte count and stamp, loads
// default capacity 65536 and ratio 2.0; slot ram contents are left as they are
module byte_budget_lru_glyph_cache
	import bblgc_pkg::*;
#(
	parameter int unsigned ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output rsp_t        rsp
);
	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(ENTRIES);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_MUL   = 11'b00000000010,
		S_LSCAN = 11'b00000000100,
		S_LDONE = 11'b00000001000,
		S_EVCHK = 11'b00000010000,
		S_LRU   = 11'b00000100000,
		S_DROP  = 11'b00001000000,
		S_FREE  = 11'b00010000000,
		S_WRITE = 11'b00100000000,
		S_CLEAR = 11'b01000000000,
		S_EMIT1 = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [BYTES_W-1:0] capacity_q;
	logic [RATIO_W-1:0] ratio_q;

	assign pready = 1'b1;
	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_RATIO) begin
			prdata = 32'(ratio_q);
		end else begin
			prdata = 32'(capacity_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			ratio_q    <= RATIO_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_RATIO) begin
				ratio_q <= pwdata[RATIO_W-1:0];
			end else begin
				capacity_q <= pwdata[BYTES_W-1:0];
			end
		end
	end

	// request registers
	req_t               r_q;
	logic [PREFIX_W-1:0] prefix;
	logic [KEY_W-1:0]    key;
	assign prefix = {r_q.font_id, r_q.glyph_number, r_q.samples_axis};
	assign key    = {prefix, r_q.scale_ppu};

	logic [ENTRIES-1:0] valid_q;
	logic [BYTES_W-1:0] used_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [PROD_W-1:0]  prod_q;

	// scan pipeline
	logic [CW-1:0] cnt_q;
	logic          p_valid_s1;
	logic [IW-1:0] p_idx_s1;

	// best candidate of the scan
	logic               found_q;
	logic               hit_q;
	logic [IW-1:0]      best_idx_q;
	logic [PPU_W-1:0]   best_ppu_q;
	logic [TAG_W-1:0]   best_tag_q;
	logic [BYTES_W-1:0] best_bytes_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic               full_q;
	logic [IW-1:0]      slot_q;
	logic [2:0]         em_status_q;

	// slot storage
	logic [IW-1:0]      raddr;
	logic [KEY_W-1:0]   key_rd;
	logic [BYTES_W-1:0] bytes_rd;
	logic [STAMP_W-1:0] stamp_rd;
	logic [TAG_W-1:0]   tag_rd;
	logic               we_all;
	logic               we_stamp;
	logic [IW-1:0]      waddr;
	logic [STAMP_W-1:0] stamp_next;

	assign stamp_next = stamp_q + STAMP_W'(1);

	bblgc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key (
		.clk(clk), .we(we_all), .waddr(waddr), .wdata(key),
		.raddr(raddr), .rdata(key_rd)
	);
	bblgc_ram #(.WIDTH(BYTES_W), .DEPTH(ENTRIES)) u_bytes (
		.clk(clk), .we(we_all), .waddr(waddr), .wdata(r_q.entry_bytes),
		.raddr(raddr), .rdata(bytes_rd)
	);
	bblgc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp (
		.clk(clk), .we(we_stamp), .waddr(waddr), .wdata(stamp_next),
		.raddr(raddr), .rdata(stamp_rd)
	);
	bblgc_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag (
		.clk(clk), .we(we_all), .waddr(waddr), .wdata(r_q.payload_tag),
		.raddr(raddr), .rdata(tag_rd)
	);

	// slot search over valid bits
	logic          any_valid;
	logic [IW-1:0] top_idx;
	logic          any_free;
	logic [IW-1:0] free_idx;
	always_comb begin
		any_valid = 1'b0;
		top_idx   = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (valid_q[i]) begin
				any_valid = 1'b1;
				top_idx   = IW'(i);
			end
		end
		any_free = 1'b0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				any_free = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	logic scanning;
	assign scanning = (state_q == S_LSCAN) || (state_q == S_LRU);

	always_comb begin
		raddr = cnt_q[IW-1:0];
		if (state_q == S_CLEAR) begin
			raddr = top_idx;
		end
	end

	// shared compare unit for the scanned slot
	logic [PPU_W-1:0] e_ppu;
	logic             p_live;
	logic             exact_m;
	logic             src_m;
	logic             lru_m;
	assign e_ppu   = key_rd[PPU_W-1:0];
	assign p_live  = p_valid_s1 && valid_q[p_idx_s1];
	assign exact_m = p_live && (key_rd == key);
	assign src_m   = p_live && (key_rd[KEY_W-1:PPU_W] == prefix) && (e_ppu > r_q.scale_ppu)
		&& (PROD_W'({e_ppu, 8'd0}) <= prod_q) && (!found_q || e_ppu < best_ppu_q);
	assign lru_m   = p_live && (!found_q || stamp_rd < best_stamp_q);

	logic rsp_free;
	assign rsp_free  = !rsp_valid || rsp_ready;
	assign req_ready = (state_q == S_IDLE);

	logic invalid_req;
	assign invalid_req = (req.command == 2'd3) || (req.samples_axis == 4'd0)
		|| (req.samples_axis > MAX_SAMPLES) || (req.scale_ppu == '0);

	logic [ENTRIES-1:0] valid_clr;
	always_comb begin
		valid_clr = valid_q;
		valid_clr[slot_q] = 1'b0;
	end

	always_comb begin
		we_all   = 1'b0;
		we_stamp = 1'b0;
		waddr    = slot_q;
		if (state_q == S_WRITE && rsp_free) begin
			we_all   = 1'b1;
			we_stamp = 1'b1;
		end
		if (state_q == S_LDONE && rsp_free && found_q) begin
			we_stamp = 1'b1;
			waddr    = best_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			r_q <= req;
		end
		if (state_q == S_MUL) begin
			prod_q <= PROD_W'(ratio_q) * PROD_W'(r_q.scale_ppu);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			valid_q      <= '0;
			used_q       <= '0;
			stamp_q      <= '0;
			cnt_q        <= '0;
			p_valid_s1   <= 1'b0;
			p_idx_s1     <= '0;
			found_q      <= 1'b0;
			hit_q        <= 1'b0;
			best_idx_q   <= '0;
			best_ppu_q   <= '0;
			best_tag_q   <= '0;
			best_bytes_q <= '0;
			best_stamp_q <= '0;
			full_q       <= 1'b0;
			slot_q       <= '0;
			em_status_q  <= ST_INVALID;
			rsp_valid    <= 1'b0;
			rsp          <= '0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				rsp_valid <= 1'b0;
			end
			if (scanning) begin
				p_valid_s1 <= (cnt_q != LAST_CNT);
				p_idx_s1   <= cnt_q[IW-1:0];
				if (cnt_q != LAST_CNT) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q      <= '0;
						p_valid_s1 <= 1'b0;
						found_q    <= 1'b0;
						hit_q      <= 1'b0;
						full_q     <= 1'b0;
						if (req.command == CMD_CLEAR) begin
							state_q <= S_CLEAR;
							slot_q  <= top_idx;
						end else if (invalid_req) begin
							em_status_q <= ST_INVALID;
							state_q     <= S_EMIT1;
						end else if (req.command == CMD_LOOKUP) begin
							state_q <= S_MUL;
						end else if (capacity_q == '0 || req.entry_bytes > capacity_q) begin
							em_status_q <= ST_NOSTORE;
							state_q     <= S_EMIT1;
						end else begin
							state_q <= S_EVCHK;
						end
					end
				end
				S_MUL: begin
					state_q <= S_LSCAN;
				end
				S_LSCAN: begin
					// first exact match wins, else smallest larger scale in ratio
					if (exact_m && !hit_q) begin
						hit_q      <= 1'b1;
						found_q    <= 1'b1;
						best_idx_q <= p_idx_s1;
						best_ppu_q <= e_ppu;
						best_tag_q <= tag_rd;
					end else if (src_m && !hit_q) begin
						found_q    <= 1'b1;
						best_idx_q <= p_idx_s1;
						best_ppu_q <= e_ppu;
						best_tag_q <= tag_rd;
					end
					if (cnt_q == LAST_CNT && !p_valid_s1) begin
						state_q <= S_LDONE;
					end
				end
				S_LDONE: begin
					if (rsp_free) begin
						rsp_valid          <= 1'b1;
						rsp.bytes_in_use   <= used_q;
						rsp.last           <= 1'b1;
						if (found_q) begin
							stamp_q            <= stamp_next;
							rsp.status         <= hit_q ? ST_HIT : ST_SOURCE;
							rsp.result_payload <= best_tag_q;
							rsp.result_ppu     <= best_ppu_q;
							rsp.slot_index     <= 6'(best_idx_q);
						end else begin
							rsp.status         <= ST_MISS;
							rsp.result_payload <= '0;
							rsp.result_ppu     <= '0;
							rsp.slot_index     <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_EVCHK: begin
					cnt_q      <= '0;
					p_valid_s1 <= 1'b0;
					found_q    <= 1'b0;
					if (used_q > capacity_q - r_q.entry_bytes) begin
						state_q <= S_LRU;
					end else begin
						state_q <= S_FREE;
					end
				end
				S_LRU: begin
					if (lru_m) begin
						found_q      <= 1'b1;
						best_idx_q   <= p_idx_s1;
						best_stamp_q <= stamp_rd;
						best_ppu_q   <= e_ppu;
						best_tag_q   <= tag_rd;
						best_bytes_q <= bytes_rd;
					end
					if (cnt_q == LAST_CNT && !p_valid_s1) begin
						state_q <= found_q ? S_DROP : S_FREE;
					end
				end
				S_DROP: begin
					if (rsp_free) begin
						valid_q[best_idx_q] <= 1'b0;
						used_q              <= used_q - best_bytes_q;
						rsp_valid           <= 1'b1;
						rsp.status          <= ST_EVICTED;
						rsp.result_payload  <= best_tag_q;
						rsp.result_ppu      <= best_ppu_q;
						rsp.slot_index      <= 6'(best_idx_q);
						rsp.bytes_in_use    <= used_q - best_bytes_q;
						rsp.last            <= 1'b0;
						if (full_q) begin
							slot_q  <= best_idx_q;
							state_q <= S_WRITE;
						end else begin
							state_q <= S_EVCHK;
						end
					end
				end
				S_FREE: begin
					if (any_free) begin
						slot_q  <= free_idx;
						state_q <= S_WRITE;
					end else begin
						// table full: one more lru eviction frees a slot
						full_q     <= 1'b1;
						cnt_q      <= '0;
						p_valid_s1 <= 1'b0;
						found_q    <= 1'b0;
						state_q    <= S_LRU;
					end
				end
				S_WRITE: begin
					if (rsp_free) begin
						valid_q[slot_q]    <= 1'b1;
						stamp_q            <= stamp_next;
						used_q             <= used_q + r_q.entry_bytes;
						rsp_valid          <= 1'b1;
						rsp.status         <= ST_STORED;
						rsp.result_payload <= r_q.payload_tag;
						rsp.result_ppu     <= r_q.scale_ppu;
						rsp.slot_index     <= 6'(slot_q);
						rsp.bytes_in_use   <= used_q + r_q.entry_bytes;
						rsp.last           <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				S_CLEAR: begin
					// top valid slot addresses the ram; its registered data is used once found_q is set
					if (!any_valid) begin
						state_q <= S_IDLE;
					end else if (!found_q) begin
						found_q <= 1'b1;
						slot_q  <= top_idx;
					end else if (rsp_free) begin
						valid_q            <= valid_clr;
						used_q             <= used_q - bytes_rd;
						rsp_valid          <= 1'b1;
						rsp.status         <= ST_CLEARED;
						rsp.result_payload <= tag_rd;
						rsp.result_ppu     <= key_rd[PPU_W-1:0];
						rsp.slot_index     <= 6'(slot_q);
						rsp.bytes_in_use   <= used_q - bytes_rd;
						rsp.last           <= (valid_clr == '0);
						found_q            <= 1'b0;
					end
				end
				S_EMIT1: begin
					if (rsp_free) begin
						rsp_valid        <= 1'b1;
						rsp.status       <= em_status_q;
						rsp.slot_index   <= '0;
						rsp.bytes_in_use <= used_q;
						rsp.last         <= 1'b1;
						if (em_status_q == ST_NOSTORE) begin
							rsp.result_payload <= r_q.payload_tag;
							rsp.result_ppu     <= r_q.scale_ppu;
						end else begin
							rsp.result_payload <= '0;
							rsp.result_ppu     <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
